// ===== rtl/lpg_pkg.sv =====
// lpg_pkg: shared types and codes of the line point generator.
// No dependencies; imported by the channel interfaces and the top level.
package lpg_pkg;

  // Request kinds on the request channel
  typedef enum logic {
    REQ_START = 1'b0,
    REQ_NEXT  = 1'b1
  } req_kind_t;

  // Step direction of one axis, two's complement of -1/0/+1
  typedef logic [1:0] dir_t;
  localparam dir_t DIR_HOLD = 2'b00;
  localparam dir_t DIR_UP   = 2'b01;
  localparam dir_t DIR_DOWN = 2'b11;

  localparam int COLOR_BITS = 16;

endpackage

// ===== rtl/lpg_req_if.sv =====
// lpg_req_if: valid/ready request channel (line start or next pixel).
// Depends on lpg_pkg for the request kind and color width.
interface lpg_req_if #(
  parameter int COORD_BITS = 10
);
  logic                          valid;
  logic                          ready;
  lpg_pkg::req_kind_t            req_type;
  logic [COORD_BITS-1:0]         x_start;
  logic [COORD_BITS-1:0]         y_start;
  logic [COORD_BITS-1:0]         x_end;
  logic [COORD_BITS-1:0]         y_end;
  logic [lpg_pkg::COLOR_BITS-1:0] pen_color;

  modport source (
    output valid, req_type, x_start, y_start, x_end, y_end, pen_color,
    input  ready
  );
  modport sink (
    input  valid, req_type, x_start, y_start, x_end, y_end, pen_color,
    output ready
  );
endinterface

// ===== rtl/lpg_pix_if.sv =====
// lpg_pix_if: valid/ready pixel channel (position, color, last flag).
// Depends on lpg_pkg for the color width.
interface lpg_pix_if #(
  parameter int COORD_BITS = 10
);
  logic                          valid;
  logic                          ready;
  logic [COORD_BITS-1:0]         pixel_x;
  logic [COORD_BITS-1:0]         pixel_y;
  logic [lpg_pkg::COLOR_BITS-1:0] pixel_color;
  logic                          last;

  modport source (
    output valid, pixel_x, pixel_y, pixel_color, last,
    input  ready
  );
  modport sink (
    input  valid, pixel_x, pixel_y, pixel_color, last,
    output ready
  );
endinterface

// ===== rtl/line_point_generator.sv =====
// line_point_generator: error-accumulation line rasterizer, top level.
// Depends on lpg_pkg, lpg_req_if and lpg_pix_if.
//
// Usage:
//   req channel: a START transfer latches both endpoints and the pen color
//     and emits nothing. Each NEXT transfer while a line is active emits one
//     pixel on the pix channel; NEXT with no active line is dropped.
//   A line gives major_len+2 pixels (major_len = larger axis delta); the
//   start pixel comes out twice and the end pixel carries last. After last
//   the line is done. START during a line abandons it.
//   Output: a NEXT transfer's pixel is registered and shows on pix in the next cycle.
//   Throughput: one request per cycle while pix is not stalled. The per-pixel
//   work (two accumulator adds, two compares against major_len, two coordinate
//   steps) sits between the line state registers and the pix output register.
//   Stall: the pix output register holds its pixel until taken; req.ready is
//   high whenever that register is empty or being drained this cycle, so a
//   request is taken in the same cycle the waiting pixel leaves.
//   Reset (rst, synchronous): no line active, pix channel empty.
module line_point_generator #(
  parameter int COORD_BITS = 10
) (
  input  logic      clk,
  input  logic      rst,
  lpg_req_if.sink   req,
  lpg_pix_if.source pix
);
  import lpg_pkg::*;

  localparam int CW = COORD_BITS;
  localparam int EW = COORD_BITS + 2;  // error accumulators
  localparam int NW = COORD_BITS + 1;  // emitted-pixel counter

  // Line state
  logic                  active;
  logic [CW-1:0]         cur_col;
  logic [CW-1:0]         cur_row;
  logic [EW-1:0]         err_col;
  logic [EW-1:0]         err_row;
  logic [CW-1:0]         abs_dx;
  logic [CW-1:0]         abs_dy;
  dir_t                  dir_col;
  dir_t                  dir_row;
  logic [CW-1:0]         major_len;
  logic [NW-1:0]         emitted;
  logic [COLOR_BITS-1:0] held_color;

  // Output register
  logic                  out_valid;
  logic [CW-1:0]         out_x;
  logic [CW-1:0]         out_y;
  logic [COLOR_BITS-1:0] out_color;
  logic                  out_last;

  logic req_fire;
  logic do_start;
  logic do_step;

  // Start-side setup
  logic [CW-1:0] dx_mag;
  logic [CW-1:0] dy_mag;
  dir_t          dx_dir;
  dir_t          dy_dir;
  logic [CW-1:0] major_new;

  // Step-side update
  logic          is_last;
  logic [EW-1:0] col_sum;
  logic [EW-1:0] row_sum;
  logic          col_step;
  logic          row_step;
  logic [EW-1:0] err_col_next;
  logic [EW-1:0] err_row_next;
  logic [CW-1:0] cur_col_next;
  logic [CW-1:0] cur_row_next;

  function automatic logic [CW-1:0] move_coord(input logic [CW-1:0] pos, input dir_t dir);
    logic [CW-1:0] res;
    unique case (dir)
      DIR_UP:   res = pos + CW'(1);
      DIR_DOWN: res = pos - CW'(1);
      default:  res = pos;  // hold
    endcase
    return res;
  endfunction

  // Output register empty or draining: safe to take a request
  assign req.ready = !out_valid || pix.ready;
  assign req_fire  = req.valid && req.ready;
  assign do_start  = req_fire && (req.req_type == REQ_START);
  assign do_step   = req_fire && (req.req_type == REQ_NEXT) && active;

  // Absolute deltas and directions
  always_comb begin
    if (req.x_end > req.x_start) begin
      dx_mag = req.x_end - req.x_start;
      dx_dir = DIR_UP;
    end else if (req.x_end == req.x_start) begin
      dx_mag = '0;
      dx_dir = DIR_HOLD;
    end else begin
      dx_mag = req.x_start - req.x_end;
      dx_dir = DIR_DOWN;
    end
    if (req.y_end > req.y_start) begin
      dy_mag = req.y_end - req.y_start;
      dy_dir = DIR_UP;
    end else if (req.y_end == req.y_start) begin
      dy_mag = '0;
      dy_dir = DIR_HOLD;
    end else begin
      dy_mag = req.y_start - req.y_end;
      dy_dir = DIR_DOWN;
    end
  end

  assign major_new = (dx_mag > dy_mag) ? dx_mag : dy_mag;

  // Per-pixel accumulator update; an axis steps when its error passes major_len
  assign is_last      = (emitted == ({1'b0, major_len} + NW'(1)));
  assign col_sum      = err_col + EW'(abs_dx);
  assign row_sum      = err_row + EW'(abs_dy);
  assign col_step     = (col_sum > EW'(major_len));
  assign row_step     = (row_sum > EW'(major_len));
  assign err_col_next = col_step ? (col_sum - EW'(major_len)) : col_sum;
  assign err_row_next = row_step ? (row_sum - EW'(major_len)) : row_sum;
  assign cur_col_next = col_step ? move_coord(cur_col, dir_col) : cur_col;
  assign cur_row_next = row_step ? move_coord(cur_row, dir_row) : cur_row;

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (do_start) begin
        active <= 1'b1;
      end else if (do_step && is_last) begin
        active <= 1'b0;
      end
      if (do_step) begin
        out_valid <= 1'b1;
      end else if (pix.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Line payload state and output pixel
  always_ff @(posedge clk) begin
    if (do_start) begin
      cur_col    <= req.x_start;
      cur_row    <= req.y_start;
      err_col    <= '0;
      err_row    <= '0;
      abs_dx     <= dx_mag;
      abs_dy     <= dy_mag;
      dir_col    <= dx_dir;
      dir_row    <= dy_dir;
      major_len  <= major_new;
      emitted    <= '0;
      held_color <= req.pen_color;
    end else if (do_step) begin
      cur_col <= cur_col_next;
      cur_row <= cur_row_next;
      err_col <= err_col_next;
      err_row <= err_row_next;
      emitted <= emitted + NW'(1);
    end
    if (do_step) begin
      out_x     <= cur_col;
      out_y     <= cur_row;
      out_color <= held_color;
      out_last  <= is_last;
    end
  end

  assign pix.valid       = out_valid;
  assign pix.pixel_x     = out_x;
  assign pix.pixel_y     = out_y;
  assign pix.pixel_color = out_color;
  assign pix.last        = out_last;

`ifndef SYNTHESIS
  // Accumulators never exceed the major distance during a line
  a_err_bound: assert property (@(posedge clk) disable iff (rst)
    active |-> (err_col <= EW'(major_len)) && (err_row <= EW'(major_len)))
    else $error("line error accumulator above major_len");

  // Pixel count stays within major_len+1 while active
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    active |-> (emitted <= ({1'b0, major_len} + NW'(1))))
    else $error("emitted count past end of line");

  // A new pixel only follows a NEXT transfer on an active line
  a_pix_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(do_step))
    else $error("pixel appeared without a NEXT transfer");

  // The last pixel always ends the line; a start cannot arrive with it on the one request channel
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (do_step && is_last) |=> !active)
    else $error("line still active after last pixel");
`endif

endmodule
